>>> design/tyta_pkg.sv
`timescale 1ns / 1ps
package tyta_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned AngW = 32;
  localparam int unsigned ForceW = 32;
  localparam int unsigned AxisW = 16;
  localparam int unsigned FracW = 14;
  localparam int unsigned CfgW = 31;
  localparam int unsigned PaddrW = 3;

  localparam int unsigned MagW = 30;
  localparam int unsigned SqRemW = 63;
  localparam int unsigned SqRootW = 31;
  localparam int unsigned DivRemW = 46;
  localparam int unsigned QuoW = 15;

  localparam logic signed [15:0] PiQ13 = 16'sd25736;
  localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;
  localparam logic signed [AngW-1:0] CordicX0 = 32'sh1000_0000;
  localparam logic [CfgW-1:0] MinForceReset = 31'd6554;
  localparam logic [QuoW-1:0] OneQ14 = 15'd16384;
  localparam logic signed [31:0] SatLimit = 32'sd16384;
  localparam logic signed [31:0] RoundQ14 = 32'sd8192;

  localparam logic [PaddrW-3:0] RegMinForce = 1'b0;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [15:0] yaw_angle;
  } in_t;

  typedef struct packed {
    logic signed [15:0] xaxis_x;
    logic signed [15:0] xaxis_y;
    logic signed [15:0] xaxis_z;
    logic signed [15:0] yaxis_x;
    logic signed [15:0] yaxis_y;
    logic signed [15:0] yaxis_z;
    logic signed [15:0] zaxis_x;
    logic signed [15:0] zaxis_y;
    logic signed [15:0] zaxis_z;
  } out_t;

  function automatic logic signed [AngW-1:0] atan_q28(input int unsigned idx);
    logic signed [AngW-1:0] r;
    case (idx)
      0:       r = 32'sd210828714;
      1:       r = 32'sd124459457;
      2:       r = 32'sd65760959;
      3:       r = 32'sd33381289;
      4:       r = 32'sd16755421;
      5:       r = 32'sd8385878;
      6:       r = 32'sd4193962;
      7:       r = 32'sd2097109;
      8:       r = 32'sd1048570;
      9:       r = 32'sd524287;
      10:      r = 32'sd262143;
      11:      r = 32'sd131071;
      12:      r = 32'sd65535;
      13:      r = 32'sd32767;
      14:      r = 32'sd16383;
      15:      r = 32'sd8191;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> design/tyta_cordic_cell.sv
`timescale 1ns / 1ps
module tyta_cordic_cell #(
  parameter int unsigned Step = 0,
  parameter int unsigned SideW = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic signed [tyta_pkg::AngW-1:0]   x_i,
  input  logic signed [tyta_pkg::AngW-1:0]   y_i,
  input  logic signed [tyta_pkg::AngW-1:0]   z_i,
  input  logic [SideW-1:0]                   side_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic signed [tyta_pkg::AngW-1:0]   x_o,
  output logic signed [tyta_pkg::AngW-1:0]   y_o,
  output logic signed [tyta_pkg::AngW-1:0]   z_o,
  output logic [SideW-1:0]                   side_o
);
  import tyta_pkg::*;

  logic                   valid_q;
  logic signed [AngW-1:0] x_q, y_q, z_q, x_d, y_d, z_d, dx, dy;
  logic [SideW-1:0]       side_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    dx = y_i >>> Step;
    dy = x_i >>> Step;
    if (z_i >= 0) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - atan_q28(Step);
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + atan_q28(Step);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

>>> design/tyta_sqrt_cell.sv
`timescale 1ns / 1ps
module tyta_sqrt_cell #(
  parameter int unsigned K = 0,
  parameter int unsigned SideW = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [tyta_pkg::SqRemW-1:0]   rem_i,
  input  logic [tyta_pkg::SqRootW-1:0]  root_i,
  input  logic [SideW-1:0]              side_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [tyta_pkg::SqRemW-1:0]   rem_o,
  output logic [tyta_pkg::SqRootW-1:0]  root_o,
  output logic [SideW-1:0]              side_o
);
  import tyta_pkg::*;

  logic               valid_q;
  logic [SqRemW-1:0]  rem_q, rem_d, trial;
  logic [SqRootW-1:0] root_q, root_d;
  logic [SideW-1:0]   side_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    trial = ({{(SqRemW-SqRootW){1'b0}}, root_i} << (K + 1))
          + ({{(SqRemW-1){1'b0}}, 1'b1} << (2 * K));
    rem_d  = rem_i;
    root_d = root_i;
    if (rem_i >= trial) begin
      rem_d     = rem_i - trial;
      root_d[K] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

>>> design/tyta_div_cell.sv
`timescale 1ns / 1ps
module tyta_div_cell #(
  parameter int unsigned J = 0,
  parameter int unsigned SideW = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic [2:0][tyta_pkg::DivRemW-1:0]  rem_i,
  input  logic [2:0][tyta_pkg::QuoW-1:0]     quo_i,
  input  logic [tyta_pkg::SqRootW-1:0]       den_i,
  input  logic [SideW-1:0]                   side_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic [2:0][tyta_pkg::DivRemW-1:0]  rem_o,
  output logic [2:0][tyta_pkg::QuoW-1:0]     quo_o,
  output logic [tyta_pkg::SqRootW-1:0]       den_o,
  output logic [SideW-1:0]                   side_o
);
  import tyta_pkg::*;

  logic                     valid_q;
  logic [2:0][DivRemW-1:0]  rem_q, rem_d;
  logic [2:0][QuoW-1:0]     quo_q, quo_d;
  logic [DivRemW-1:0]       dsh;
  logic [SqRootW-1:0]       den_q;
  logic [SideW-1:0]         side_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    dsh   = {{(DivRemW-SqRootW){1'b0}}, den_i} << J;
    rem_d = rem_i;
    quo_d = quo_i;
    for (int c = 0; c < 3; c++) begin
      if (rem_i[c] >= dsh) begin
        rem_d[c]    = rem_i[c] - dsh;
        quo_d[c][J] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      den_q  <= den_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign den_o   = den_q;
  assign side_o  = side_q;

endmodule

>>> design/tyta_norm.sv
`timescale 1ns / 1ps
module tyta_norm #(
  parameter int unsigned W = 64,
  parameter int unsigned SideW = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic [2:0][W-1:0]                vec_i,
  input  logic [SideW-1:0]                 side_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic [2:0][tyta_pkg::AxisW-1:0]  axis_o,
  output logic [SideW-1:0]                 side_o
);
  import tyta_pkg::*;

  localparam int unsigned ShW = $clog2(W);
  localparam int unsigned TopBit = MagW - 1;
  localparam int unsigned SqSideW = 3 + 3 * MagW + SideW;
  localparam int unsigned DvSideW = 3 + SideW;

  // Stage A: sign and magnitude, largest magnitude.
  logic               a_valid_q, a_ready;
  logic [2:0]         a_neg_q, a_neg_d;
  logic [2:0][W-1:0]  a_mag_q, a_mag_d;
  logic [W-1:0]       a_mx_q, a_mx_d;
  logic [SideW-1:0]   a_side_q;
  // Stage B: shift that brings the largest magnitude into [2^29, 2^30).
  logic               b_valid_q, b_ready;
  logic [ShW-1:0]     b_pos, b_amt_q, b_amt_d;
  logic               b_right_q, b_right_d;
  logic [2:0]         b_neg_q;
  logic [2:0][W-1:0]  b_mag_q;
  logic [SideW-1:0]   b_side_q;
  // Stage C: shifted magnitudes.
  logic                  c_valid_q, c_ready;
  logic [2:0]            c_neg_q;
  logic [2:0][MagW-1:0]  c_mag_q, c_mag_d;
  logic [SideW-1:0]      c_side_q;
  // Stage D: squares.
  logic                    d_valid_q, d_ready;
  logic [2:0]              d_neg_q;
  logic [2:0][MagW-1:0]    d_mag_q;
  logic [2:0][2*MagW-1:0]  d_sq_q, d_sq_d;
  logic [SideW-1:0]        d_side_q;
  // Stage E: sum of squares.
  logic                  e_valid_q, e_ready;
  logic [2:0]            e_neg_q;
  logic [2:0][MagW-1:0]  e_mag_q;
  logic [SqRemW-1:0]     e_sum_q;
  logic [SideW-1:0]      e_side_q;
  // Square root cells.
  logic                sq_valid [SqRootW+1];
  logic                sq_ready [SqRootW+1];
  logic [SqRemW-1:0]   sq_rem   [SqRootW+1];
  logic [SqRootW-1:0]  sq_root  [SqRootW+1];
  logic [SqSideW-1:0]  sq_side  [SqRootW+1];
  // Stage F: dividends.
  logic                     f_valid_q, f_ready;
  logic [2:0]               f_neg_in;
  logic [2:0][MagW-1:0]     f_mag_in;
  logic [SideW-1:0]         f_side_in;
  logic [2:0][DivRemW-1:0]  f_rem_q, f_rem_d;
  logic [SqRootW-1:0]       f_den_q;
  logic [2:0]               f_neg_q;
  logic [SideW-1:0]         f_side_q;
  // Division cells.
  logic                     dv_valid [QuoW+1];
  logic                     dv_ready [QuoW+1];
  logic [2:0][DivRemW-1:0]  dv_rem   [QuoW+1];
  logic [2:0][QuoW-1:0]     dv_quo   [QuoW+1];
  logic [SqRootW-1:0]       dv_den   [QuoW+1];
  logic [DvSideW-1:0]       dv_side  [QuoW+1];
  // Stage G: clamp and sign.
  logic                   g_valid_q, g_ready;
  logic [2:0]             g_neg;
  logic [SideW-1:0]       g_side_in;
  logic [2:0][QuoW-1:0]   g_qc;
  logic [2:0][AxisW-1:0]  g_axis_q, g_axis_d;
  logic [SideW-1:0]       g_side_q;

  assign ready_o = a_ready;

  assign a_ready = !a_valid_q || b_ready;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      a_neg_d[c] = vec_i[c][W-1];
      a_mag_d[c] = a_neg_d[c] ? (~vec_i[c] + W'(1)) : vec_i[c];
    end
    a_mx_d = a_mag_d[0];
    if (a_mag_d[1] > a_mx_d) begin
      a_mx_d = a_mag_d[1];
    end
    if (a_mag_d[2] > a_mx_d) begin
      a_mx_d = a_mag_d[2];
    end
  end

  assign b_ready = !b_valid_q || c_ready;
  always_comb begin
    b_pos = '0;
    for (int i = 0; i < W; i++) begin
      if (a_mx_q[i]) begin
        b_pos = ShW'(i);
      end
    end
    b_right_d = b_pos > ShW'(TopBit);
    b_amt_d   = b_right_d ? (b_pos - ShW'(TopBit)) : (ShW'(TopBit) - b_pos);
  end

  assign c_ready = !c_valid_q || d_ready;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      c_mag_d[c] = b_right_q ? MagW'(b_mag_q[c] >> b_amt_q) : MagW'(b_mag_q[c] << b_amt_q);
    end
  end

  assign d_ready = !d_valid_q || e_ready;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      d_sq_d[c] = c_mag_q[c] * c_mag_q[c];
    end
  end

  assign e_ready = !e_valid_q || sq_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
      g_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      if (c_ready) begin
        c_valid_q <= b_valid_q;
      end
      if (d_ready) begin
        d_valid_q <= c_valid_q;
      end
      if (e_ready) begin
        e_valid_q <= d_valid_q;
      end
      if (f_ready) begin
        f_valid_q <= sq_valid[SqRootW];
      end
      if (g_ready) begin
        g_valid_q <= dv_valid[QuoW];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      a_neg_q  <= a_neg_d;
      a_mag_q  <= a_mag_d;
      a_mx_q   <= a_mx_d;
      a_side_q <= side_i;
    end
    if (b_ready && a_valid_q) begin
      b_right_q <= b_right_d;
      b_amt_q   <= b_amt_d;
      b_neg_q   <= a_neg_q;
      b_mag_q   <= a_mag_q;
      b_side_q  <= a_side_q;
    end
    if (c_ready && b_valid_q) begin
      c_neg_q  <= b_neg_q;
      c_mag_q  <= c_mag_d;
      c_side_q <= b_side_q;
    end
    if (d_ready && c_valid_q) begin
      d_neg_q  <= c_neg_q;
      d_mag_q  <= c_mag_q;
      d_sq_q   <= d_sq_d;
      d_side_q <= c_side_q;
    end
    if (e_ready && d_valid_q) begin
      e_neg_q  <= d_neg_q;
      e_mag_q  <= d_mag_q;
      e_sum_q  <= SqRemW'(d_sq_q[0]) + SqRemW'(d_sq_q[1]) + SqRemW'(d_sq_q[2]);
      e_side_q <= d_side_q;
    end
    if (f_ready && sq_valid[SqRootW]) begin
      f_rem_q  <= f_rem_d;
      f_den_q  <= sq_root[SqRootW];
      f_neg_q  <= f_neg_in;
      f_side_q <= f_side_in;
    end
    if (g_ready && dv_valid[QuoW]) begin
      g_axis_q <= g_axis_d;
      g_side_q <= g_side_in;
    end
  end

  assign sq_valid[0] = e_valid_q;
  assign sq_rem[0]   = e_sum_q;
  assign sq_root[0]  = '0;
  assign sq_side[0]  = {e_neg_q, e_mag_q, e_side_q};

  for (genvar s = 0; s < SqRootW; s++) begin : g_sq
    tyta_sqrt_cell #(
      .K     (SqRootW - 1 - s),
      .SideW (SqSideW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_valid[s]),
      .ready_o (sq_ready[s]),
      .rem_i   (sq_rem[s]),
      .root_i  (sq_root[s]),
      .side_i  (sq_side[s]),
      .valid_o (sq_valid[s+1]),
      .ready_i (sq_ready[s+1]),
      .rem_o   (sq_rem[s+1]),
      .root_o  (sq_root[s+1]),
      .side_o  (sq_side[s+1])
    );
  end

  assign sq_ready[SqRootW] = f_ready;

  assign f_ready = !f_valid_q || dv_ready[0];
  assign {f_neg_in, f_mag_in, f_side_in} = sq_side[SqRootW];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      f_rem_d[c] = DivRemW'({f_mag_in[c], {FracW{1'b0}}})
                 + DivRemW'(sq_root[SqRootW] >> 1);
    end
  end

  assign dv_valid[0] = f_valid_q;
  assign dv_rem[0]   = f_rem_q;
  assign dv_quo[0]   = '0;
  assign dv_den[0]   = f_den_q;
  assign dv_side[0]  = {f_neg_q, f_side_q};

  for (genvar s = 0; s < QuoW; s++) begin : g_dv
    tyta_div_cell #(
      .J     (QuoW - 1 - s),
      .SideW (DvSideW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_valid[s]),
      .ready_o (dv_ready[s]),
      .rem_i   (dv_rem[s]),
      .quo_i   (dv_quo[s]),
      .den_i   (dv_den[s]),
      .side_i  (dv_side[s]),
      .valid_o (dv_valid[s+1]),
      .ready_i (dv_ready[s+1]),
      .rem_o   (dv_rem[s+1]),
      .quo_o   (dv_quo[s+1]),
      .den_o   (dv_den[s+1]),
      .side_o  (dv_side[s+1])
    );
  end

  assign dv_ready[QuoW] = g_ready;

  assign g_ready = !g_valid_q || ready_i;
  assign {g_neg, g_side_in} = dv_side[QuoW];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      g_qc[c]     = (dv_quo[QuoW][c] > OneQ14) ? OneQ14 : dv_quo[QuoW][c];
      g_axis_d[c] = g_neg[c] ? (AxisW'(0) - {1'b0, g_qc[c]}) : {1'b0, g_qc[c]};
    end
  end

  assign valid_o = g_valid_q;
  assign axis_o  = g_axis_q;
  assign side_o  = g_side_q;

endmodule

>>> design/thrust_yaw_to_attitude_core.sv
`timescale 1ns / 1ps
// Turns a desired force vector (Q16.16) and a yaw reference (Q2.13 radians) into the rows
// of the desired body rotation matrix in Q1.14. The block is one pipeline with valid and
// ready at both ends and takes one request in every clock cycle while the output is not
// stalled; a request passes through the 16-cell sine and cosine chain and two normalizers,
// each with a 31-cell square root chain and a 15-cell divider chain. A stalled output only
// holds the stages that are full, so empty stages keep filling. The minimum vertical
// force register sits at address 0 of the APB port and resets to 6554.
module thrust_yaw_to_attitude_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tyta_pkg::PaddrW-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  tyta_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output tyta_pkg::out_t                   out_data_o
);
  import tyta_pkg::*;

  localparam int unsigned CdSideW = 1 + 3 * ForceW;

  function automatic logic signed [AxisW-1:0] cross_q14(
    input logic signed [AxisW-1:0] a,
    input logic signed [AxisW-1:0] b,
    input logic signed [AxisW-1:0] c,
    input logic signed [AxisW-1:0] d
  );
    logic signed [31:0] s;
    logic signed [31:0] r;
    logic signed [AxisW-1:0] o;
    s = 32'(a) * 32'(b) - 32'(c) * 32'(d) + RoundQ14;
    r = s >>> FracW;
    if (r > SatLimit) begin
      o = AxisW'(SatLimit);
    end else if (r < -SatLimit) begin
      o = AxisW'(-SatLimit);
    end else begin
      o = AxisW'(r);
    end
    return o;
  endfunction

  logic [CfgW-1:0] cfg_q;
  logic            cfg_sel;

  logic                     s0_valid_q, s0_ready;
  logic signed [ForceW-1:0] s0_fx_q, s0_fy_q, s0_fz_q, s0_fz_d, s0_floor;
  logic signed [AngW-1:0]   s0_z_q, s0_z_d;
  logic signed [15:0]       s0_ang;
  logic                     s0_flip_q, s0_flip_d;

  logic                   cd_valid [CordicSteps+1];
  logic                   cd_ready [CordicSteps+1];
  logic signed [AngW-1:0] cd_x     [CordicSteps+1];
  logic signed [AngW-1:0] cd_y     [CordicSteps+1];
  logic signed [AngW-1:0] cd_z     [CordicSteps+1];
  logic [CdSideW-1:0]     cd_side  [CordicSteps+1];

  logic                     p_valid_q, p_ready, p_flip;
  logic signed [AngW-1:0]   p_hx, p_hy;
  logic signed [ForceW-1:0] p_fx, p_fy, p_fz;
  logic signed [63:0]       p_a_q, p_b_q, p_c_q, p_d_q;
  logic [3*ForceW-1:0]      p_f_q;

  logic                x_valid_q, x_ready;
  logic [2:0][63:0]    x_vec_q;
  logic [3*ForceW-1:0] x_f_q;

  logic                   nx_valid, nx_ready;
  logic [2:0][AxisW-1:0]  nx_axis;
  logic [3*ForceW-1:0]    nx_f;
  logic [2:0][ForceW-1:0] nf_vec;
  logic                   nf_valid, nf_ready;
  logic [2:0][AxisW-1:0]  nf_axis, nf_xr;
  logic [3*AxisW-1:0]     nf_side;

  logic out_valid_q, o_ready;
  out_t out_data_q, out_data_d;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[PaddrW-1:2] == RegMinForce;
  assign prdata  = cfg_sel ? {1'b0, cfg_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= MinForceReset;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      cfg_q <= pwdata[CfgW-1:0];
    end
  end

  assign s0_ready   = !s0_valid_q || cd_ready[0];
  assign in_ready_o = s0_ready;

  always_comb begin
    s0_floor  = (cfg_q == '0) ? ForceW'(1) : $signed({1'b0, cfg_q});
    s0_fz_d   = (in_data_i.force_z < s0_floor) ? s0_floor : in_data_i.force_z;
    s0_ang    = in_data_i.yaw_angle;
    s0_flip_d = 1'b0;
    if (in_data_i.yaw_angle > HalfPiQ13) begin
      s0_ang    = in_data_i.yaw_angle - PiQ13;
      s0_flip_d = 1'b1;
    end else if (in_data_i.yaw_angle < -HalfPiQ13) begin
      s0_ang    = in_data_i.yaw_angle + PiQ13;
      s0_flip_d = 1'b1;
    end
    s0_z_d = AngW'($signed({s0_ang, 15'b0}));
  end

  assign cd_valid[0] = s0_valid_q;
  assign cd_x[0]     = CordicX0;
  assign cd_y[0]     = '0;
  assign cd_z[0]     = s0_z_q;
  assign cd_side[0]  = {s0_flip_q, s0_fx_q, s0_fy_q, s0_fz_q};

  for (genvar s = 0; s < CordicSteps; s++) begin : g_cd
    tyta_cordic_cell #(
      .Step  (s),
      .SideW (CdSideW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cd_valid[s]),
      .ready_o (cd_ready[s]),
      .x_i     (cd_x[s]),
      .y_i     (cd_y[s]),
      .z_i     (cd_z[s]),
      .side_i  (cd_side[s]),
      .valid_o (cd_valid[s+1]),
      .ready_i (cd_ready[s+1]),
      .x_o     (cd_x[s+1]),
      .y_o     (cd_y[s+1]),
      .z_o     (cd_z[s+1]),
      .side_o  (cd_side[s+1])
    );
  end

  assign cd_ready[CordicSteps] = p_ready;

  assign p_ready = !p_valid_q || x_ready;
  assign {p_flip, p_fx, p_fy, p_fz} = cd_side[CordicSteps];
  always_comb begin
    p_hx = p_flip ? cd_y[CordicSteps] : -cd_y[CordicSteps];
    p_hy = p_flip ? -cd_x[CordicSteps] : cd_x[CordicSteps];
  end

  assign x_ready = !x_valid_q || nx_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      p_valid_q   <= 1'b0;
      x_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s0_ready) begin
        s0_valid_q <= in_valid_i;
      end
      if (p_ready) begin
        p_valid_q <= cd_valid[CordicSteps];
      end
      if (x_ready) begin
        x_valid_q <= p_valid_q;
      end
      if (o_ready) begin
        out_valid_q <= nf_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_ready && in_valid_i) begin
      s0_fx_q   <= in_data_i.force_x;
      s0_fy_q   <= in_data_i.force_y;
      s0_fz_q   <= s0_fz_d;
      s0_z_q    <= s0_z_d;
      s0_flip_q <= s0_flip_d;
    end
    if (p_ready && cd_valid[CordicSteps]) begin
      p_a_q <= p_hy * p_fz;
      p_b_q <= p_hx * p_fz;
      p_c_q <= p_hx * p_fy;
      p_d_q <= p_hy * p_fx;
      p_f_q <= {p_fx, p_fy, p_fz};
    end
    if (x_ready && p_valid_q) begin
      x_vec_q[0] <= p_a_q;
      x_vec_q[1] <= -p_b_q;
      x_vec_q[2] <= p_c_q - p_d_q;
      x_f_q      <= p_f_q;
    end
    if (o_ready && nf_valid) begin
      out_data_q <= out_data_d;
    end
  end

  tyta_norm #(
    .W     (64),
    .SideW (3 * ForceW)
  ) u_norm_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (x_valid_q),
    .ready_o (nx_ready),
    .vec_i   (x_vec_q),
    .side_i  (x_f_q),
    .valid_o (nx_valid),
    .ready_i (nf_ready),
    .axis_o  (nx_axis),
    .side_o  (nx_f)
  );

  assign {nf_vec[0], nf_vec[1], nf_vec[2]} = nx_f;

  tyta_norm #(
    .W     (ForceW),
    .SideW (3 * AxisW)
  ) u_norm_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (nx_valid),
    .ready_o (nf_ready),
    .vec_i   (nf_vec),
    .side_i  (nx_axis),
    .valid_o (nf_valid),
    .ready_i (o_ready),
    .axis_o  (nf_axis),
    .side_o  (nf_side)
  );

  assign nf_xr   = nf_side;
  assign o_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_data_d.xaxis_x = nf_xr[0];
    out_data_d.xaxis_y = nf_xr[1];
    out_data_d.xaxis_z = nf_xr[2];
    out_data_d.zaxis_x = nf_axis[0];
    out_data_d.zaxis_y = nf_axis[1];
    out_data_d.zaxis_z = nf_axis[2];
    out_data_d.yaxis_x = cross_q14(nf_axis[1], nf_xr[2], nf_axis[2], nf_xr[1]);
    out_data_d.yaxis_y = cross_q14(nf_axis[2], nf_xr[0], nf_axis[0], nf_xr[2]);
    out_data_d.yaxis_z = cross_q14(nf_axis[0], nf_xr[1], nf_axis[1], nf_xr[0]);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  a_clamped_fz_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_valid_q |-> s0_fz_q > 0)
    else $error("clamped vertical force is not positive");

  a_zaxis_z_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.zaxis_z >= 0)
    else $error("body z axis points downward");

  a_xaxis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.xaxis_x <= 16'sd16384 && out_data_o.xaxis_x >= -16'sd16384
                     && out_data_o.xaxis_z <= 16'sd16384
                     && out_data_o.xaxis_z >= -16'sd16384))
    else $error("body x axis component out of range");
`endif

endmodule
